// ===== design/mfbr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the MSB-first bit reader: item and result types, command codes,
// sequencer states and fixed widths. No dependencies.
package mfbr_pkg;

    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;
    localparam int BPOS_W = 3;
    localparam int FIELD_W = 32;
    localparam int ACC_W  = 40;   // up to five buffer bytes
    localparam int NB_W   = 3;    // byte count of one read, 0..5

    localparam logic [CNT_W-1:0] MAX_FIELD_BITS = 6'd32;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SEEK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] byte_addr;
        logic [BYTE_W-1:0] byte_value;
        logic [BPOS_W-1:0] bit_pos;
        logic [CNT_W-1:0]  bit_count;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic [ADDR_W-1:0]  next_byte_addr;
        logic [BPOS_W-1:0]  next_bit_pos;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// ===== design/msb_first_bit_reader.sv =====
`timescale 1ns / 1ps
// Top level of the MSB-first bit reader: sequencer, read position and result
// register. Depends on mfbr_pkg, mfbr_byte_mem and mfbr_field_align.
//
// Usage:
//   Present an item on item and raise start; it is taken at a clock edge where
//   start is high and busy is low. Commands: load writes byte_value at
//   byte_addr, seek sets the read position, read extracts bit_count bits
//   (clamped to 32) MSB first and advances the position. Byte addresses wrap
//   at BUF_DEPTH. Every item gives one result on result, strobed by done for
//   exactly one cycle; the receiver cannot stall it and must take it then.
// Timing:
//   Load, seek and the unused code: result in the cycle after acceptance,
//   busy stays low, so one item per cycle.
//   Read of n = ceil((bit position + count) / 8) bytes (1 to 5): the sequencer
//   steps through the read state, fetching the bytes, and then the done state;
//   busy stays high until the result is strobed. A read of zero bits skips the
//   buffer and goes straight to the done state before its result is strobed.
//   The single-port buffer hands over one byte a cycle.
// Reset:
//   rst_n clears the position to byte 0, bit 0 and the sequencer to idle.
//   Buffer contents are undefined until loaded.
module msb_first_bit_reader #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mfbr_pkg::item_t   item,
    output logic             done,
    output mfbr_pkg::result_t result
);
    import mfbr_pkg::*;

    localparam int PW = $clog2(BUF_DEPTH);
    localparam logic [31:0]   DEPTH32 = BUF_DEPTH;
    localparam logic [PW-1:0] LAST    = PW'(BUF_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W = (PW+1)'(BUF_DEPTH);

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [BPOS_W-1:0] bit_reg, bit_next;
    logic [PW-1:0]     rd_addr_reg, rd_addr_next;
    logic [NB_W-1:0]   k_reg, k_next;
    logic [NB_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    result_t           res_reg, res_next;
    logic              done_reg, done_next;

    logic              accept;
    logic [16:0]       rem;
    logic [PW-1:0]     in_addr_wrapped;
    logic [CNT_W-1:0]  cnt_clamped;
    logic [CNT_W-1:0]  bits_total;
    logic [CNT_W-1:0]  shift;
    logic [PW:0]       pos_sum;
    logic [PW-1:0]     pos_adv;
    logic [FIELD_W-1:0] field;
    logic [PW-1:0]     mem_addr;
    logic              mem_we;
    logic              mem_re;
    logic [7:0]        mem_rdata;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Reduce the input address modulo the depth by restoring subtraction.
    always_comb
    begin
        rem = 17'(item.byte_addr);
        for (int s = 7; s >= 0; s--)
        begin
            if (32'(rem) >= (DEPTH32 << s))
            begin
                rem = 17'(32'(rem) - (DEPTH32 << s));
            end
        end
        in_addr_wrapped = PW'(rem);
    end

    // Field length and byte span of a read, from the current bit position.
    always_comb
    begin
        cnt_clamped = (item.bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : item.bit_count;
        bits_total  = CNT_W'(bit_reg) + cnt_clamped;
    end

    // Alignment shift and position advance for the read in flight.
    logic [CNT_W-1:0] end_bits;
    assign end_bits = CNT_W'(bit_reg) + cnt_reg;
    assign shift    = {n_reg, 3'b000} - end_bits;

    always_comb
    begin
        pos_sum = {1'b0, pos_reg} + (PW+1)'(end_bits[CNT_W-1:3]);
        if (pos_sum >= DEPTH_W)
        begin
            pos_sum = pos_sum - DEPTH_W;
        end
        pos_adv = pos_sum[PW-1:0];
    end

    mfbr_field_align u_align (
        .acc   (acc_reg),
        .shift (shift),
        .count (cnt_reg),
        .field (field)
    );

    assign mem_addr = (state_reg == ST_IDLE) ? in_addr_wrapped : rd_addr_reg;

    mfbr_byte_mem #(
        .DEPTH (BUF_DEPTH),
        .AW    (PW)
    ) u_mem (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (item.byte_value),
        .re    (mem_re),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        k_reg       <= k_next;
        n_reg       <= n_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        bit_next     = bit_reg;
        rd_addr_next = rd_addr_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.field_value = '0;
                    if (item.command == CMD_READ)
                    begin
                        // Gather ceil((bit + count) / 8) bytes from the current byte.
                        cnt_next     = cnt_clamped;
                        n_next       = NB_W'((bits_total + 6'd7) >> 3);
                        k_next       = '0;
                        acc_next     = '0;
                        rd_addr_next = pos_reg;
                        state_next   = (cnt_clamped == '0) ? ST_DONE : ST_READ;
                    end
                    else
                    begin
                        // Load, seek and the unused code finish at once.
                        done_next = 1'b1;
                        res_next.next_byte_addr = ADDR_W'(pos_reg);
                        res_next.next_bit_pos   = bit_reg;
                        if (item.command == CMD_LOAD)
                        begin
                            mem_we = 1'b1;
                        end
                        else if (item.command == CMD_SEEK)
                        begin
                            pos_next = in_addr_wrapped;
                            bit_next = item.bit_pos;
                            res_next.next_byte_addr = ADDR_W'(in_addr_wrapped);
                            res_next.next_bit_pos   = item.bit_pos;
                        end
                    end
                end
            end

            ST_READ:
            begin
                // Issue byte k and shift in byte k - 1 in the same cycle.
                if (k_reg < n_reg)
                begin
                    mem_re       = 1'b1;
                    rd_addr_next = (rd_addr_reg == LAST) ? '0 : rd_addr_reg + 1'b1;
                end
                if (k_reg != '0)
                begin
                    acc_next = {acc_reg[ACC_W-9:0], mem_rdata};
                end
                k_next = k_reg + 1'b1;
                if (k_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                pos_next  = pos_adv;
                bit_next  = end_bits[2:0];
                done_next = 1'b1;
                res_next.field_value    = field;
                res_next.next_byte_addr = ADDR_W'(pos_adv);
                res_next.next_bit_pos   = end_bits[2:0];
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The byte counter never runs past the span of the read.
    a_k_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (k_reg <= n_reg))
        else $error("byte counter past read span");

    // A non-read item gives its result in the next cycle.
    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.command != CMD_READ) |=> done)
        else $error("missing result after load or seek");

    // Non-read commands return a zero field.
    a_zero_field: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.command != CMD_READ) |=> (result.field_value == '0))
        else $error("nonzero field for load or seek");

    // A result leaves the sequencer idle and ready.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // The buffer is never written during a read.
    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !mem_we)
        else $error("buffer write during read");

endmodule

// ===== design/mfbr_byte_mem.sv =====
`timescale 1ns / 1ps
// Single-port byte buffer with registered read data.
// Depends on nothing but its parameters.
module mfbr_byte_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic [AW-1:0] addr,
    input  logic          we,
    input  logic [7:0]    wdata,
    input  logic          re,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== design/mfbr_field_align.sv =====
`timescale 1ns / 1ps
// Shift unit: right-aligns the gathered bytes and masks to the field length.
// Depends on mfbr_pkg.
module mfbr_field_align (
    input  logic [mfbr_pkg::ACC_W-1:0]   acc,
    input  logic [mfbr_pkg::CNT_W-1:0]   shift,
    input  logic [mfbr_pkg::CNT_W-1:0]   count,
    output logic [mfbr_pkg::FIELD_W-1:0] field
);
    import mfbr_pkg::*;

    logic [ACC_W-1:0]   shifted;
    logic [FIELD_W:0]   mask;

    always_comb
    begin
        shifted = acc >> shift;
        mask    = (33'd1 << count) - 33'd1;
        field   = shifted[FIELD_W-1:0] & mask[FIELD_W-1:0];
    end

endmodule

// ===== sim/tb_msb_first_bit_reader.sv =====
`timescale 1ns / 1ps
// Testbench for msb_first_bit_reader: directed and random command items checked
// against a bit-serial predictor of the read position. Depends on mfbr_pkg and the RTL.
module tb_msb_first_bit_reader;

    import mfbr_pkg::*;

    localparam int         DEPTH      = 4096;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         PHASES     = 4;
    localparam int         PHASE_ITEMS = 380;
    localparam int         ITEM_W     = $bits(item_t);

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   cmd_item = '0;
    logic    done;
    result_t reader_result;

    msb_first_bit_reader #(
        .BUF_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(cmd_item),
        .done(done),
        .result(reader_result)
    );

    always #5 clk = ~clk;

    // Items waiting for the driver, and results owed by the block in order.
    item_t   pending_items[$];
    result_t expected_results[$];

    int planned_count = 0;
    int taken_count = 0;
    int mismatch_count = 0;

    // Predicted block state: buffer contents and the read position.
    logic [7:0]  stream_mem [DEPTH];
    logic [11:0] stream_byte = '0;
    logic [2:0]  stream_bit = '0;

    // Position as the stimulus planner sees it, plus which entries hold data.
    // Reads are only planned over loaded entries.
    logic [11:0] plan_byte = '0;
    logic [2:0]  plan_bit = '0;
    bit          plan_written [DEPTH];

    int burst_left = 1;
    int gap_left = 0;

    // Apply one item to the predicted state and return the result it owes.
    // Reads walk the stream one bit at a time, MSB of each byte first.
    function automatic result_t read_stream(input item_t it);
        result_t    r;
        logic [5:0] n;
        r = '0;
        case (it.command)
            CMD_LOAD: stream_mem[it.byte_addr] = it.byte_value;
            CMD_SEEK:
            begin
                stream_byte = it.byte_addr;
                stream_bit = it.bit_pos;
            end
            CMD_READ:
            begin
                n = (it.bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : it.bit_count;
                for (int i = 0; i < n; i++)
                begin
                    r.field_value = {r.field_value[30:0],
                                     stream_mem[stream_byte][3'd7 - stream_bit]};
                    stream_bit = stream_bit + 3'd1;
                    if (stream_bit == 3'd0)
                        stream_byte = stream_byte + 12'd1;  // wraps at the depth
                end
            end
            default: ;  // unused code: nothing moves
        endcase
        r.next_byte_addr = stream_byte;
        r.next_bit_pos = stream_bit;
        return r;
    endfunction

    // True when every byte a read of cnt bits would touch has been loaded.
    function automatic bit span_loaded(input logic [5:0] cnt);
        int          c;
        int          nbytes;
        logic [11:0] a;
        c = (cnt > MAX_FIELD_BITS) ? 32 : cnt;
        nbytes = (plan_bit + c + 7) / 8;
        for (int i = 0; i < nbytes; i++)
        begin
            a = plan_byte + 12'(i);
            if (!plan_written[a])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Append an item for the driver and advance the planner's view.
    function automatic void queue_item(input item_t it);
        int total;
        pending_items.push_back(it);
        planned_count++;
        case (it.command)
            CMD_LOAD: plan_written[it.byte_addr] = 1'b1;
            CMD_SEEK:
            begin
                plan_byte = it.byte_addr;
                plan_bit = it.bit_pos;
            end
            CMD_READ:
            begin
                total = plan_bit + ((it.bit_count > MAX_FIELD_BITS) ? 32 : it.bit_count);
                plan_byte = plan_byte + 12'(total / 8);
                plan_bit = 3'(total % 8);
            end
            default: ;
        endcase
    endfunction

    function automatic item_t make_item(input logic [1:0] cmd, input logic [11:0] addr,
                                        input logic [7:0] value, input logic [2:0] bpos,
                                        input logic [5:0] cnt);
        item_t it;
        it.command = cmd;
        it.byte_addr = addr;
        it.byte_value = value;
        it.bit_pos = bpos;
        it.bit_count = cnt;
        return it;
    endfunction

    // Random fields everywhere, so the ones a command ignores still toggle.
    function automatic item_t rand_item(input logic [1:0] cmd);
        item_t it;
        it = item_t'(ITEM_W'($urandom));
        it.command = cmd;
        return it;
    endfunction

    // Mostly mid-size counts, with zero and oversized counts mixed in.
    function automatic logic [5:0] pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 6'd0;
        if (roll == 1)
            return 6'($urandom_range(33, 63));
        if (roll < 5)
            return 6'($urandom_range(25, 32));
        return 6'($urandom_range(1, 24));
    endfunction

    // Well-formed sequence: load a run of bytes, seek into it, read it back.
    task automatic plan_packet();
        logic [11:0] base;
        int          len;
        int          reads;
        item_t       it;
        // a quarter of the runs start in the last six entries, so they may straddle the top
        base = ($urandom_range(0, 3) == 0) ? 12'(DEPTH - $urandom_range(1, 6))
                                           : 12'($urandom);
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++)
        begin
            it = rand_item(CMD_LOAD);
            it.byte_addr = base + 12'(i);
            queue_item(it);
        end
        it = rand_item(CMD_SEEK);
        it.byte_addr = base;
        queue_item(it);
        reads = $urandom_range(1, 8);
        for (int i = 0; i < reads; i++)
        begin
            it = rand_item(CMD_READ);
            it.bit_count = pick_count();
            if (!span_loaded(it.bit_count))
                break;
            queue_item(it);
        end
    endtask

    // Noise: unused code, stray seeks and loads, reads wherever it is safe.
    task automatic plan_noise();
        item_t it;
        case ($urandom_range(0, 3))
            0: queue_item(rand_item(CMD_UNUSED));
            1: queue_item(rand_item(CMD_SEEK));
            2: queue_item(rand_item(CMD_LOAD));
            default:
            begin
                it = rand_item(CMD_READ);
                it.bit_count = pick_count();
                if (span_loaded(it.bit_count))
                    queue_item(it);
            end
        endcase
    endtask

    // Hold the stimulus until the block has drained every owed result.
    task automatic wait_drained();
        while (taken_count < planned_count || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: present pending items in bursts with random gaps. Hold an item
    // while busy; predict its result at the edge that takes it.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        bit took;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd_item <= '0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                expected_results.push_back(read_stream(cmd_item));
                taken_count++;
            end
            if (start && !took)
                ;  // hold the item until the block takes it
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cmd_item <= pending_items.pop_front();
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 5))
                        0, 1: gap_left = 0;
                        2, 3, 4: gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 20);
                    endcase
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result must match the oldest owed result.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result strobed with none owed: field_value %h addr %h bit %0d",
                       reader_result.field_value, reader_result.next_byte_addr,
                       reader_result.next_bit_pos);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (reader_result.field_value !== want.field_value)
                begin
                    $error("field_value: expected %h, got %h",
                           want.field_value, reader_result.field_value);
                    mismatch_count++;
                end
                if (reader_result.next_byte_addr !== want.next_byte_addr)
                begin
                    $error("next_byte_addr: expected %h, got %h",
                           want.next_byte_addr, reader_result.next_byte_addr);
                    mismatch_count++;
                end
                if (reader_result.next_bit_pos !== want.next_bit_pos)
                begin
                    $error("next_bit_pos: expected %0d, got %0d",
                           want.next_bit_pos, reader_result.next_bit_pos);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero count at reset, unused code, extreme bytes, a full
        // 32-bit read wrapping past the last entry, oversized counts, reads
        // that end exactly on a byte boundary and reads that straddle one.
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd0));
        queue_item(rand_item(CMD_UNUSED));
        queue_item(make_item(CMD_LOAD, 12'd4095, 8'hFF, 3'd0, 6'd0));
        queue_item(make_item(CMD_LOAD, 12'd0, 8'h00, 3'd0, 6'd0));
        queue_item(make_item(CMD_LOAD, 12'd1, 8'hA5, 3'd0, 6'd0));
        queue_item(make_item(CMD_LOAD, 12'd2, 8'h3C, 3'd0, 6'd0));
        queue_item(make_item(CMD_LOAD, 12'd3, 8'hFF, 3'd0, 6'd0));
        queue_item(make_item(CMD_LOAD, 12'd4, 8'h81, 3'd0, 6'd0));
        queue_item(make_item(CMD_LOAD, 12'd5, 8'h5A, 3'd0, 6'd0));
        queue_item(make_item(CMD_SEEK, 12'd4095, 8'd0, 3'd7, 6'd0));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd32));
        queue_item(make_item(CMD_SEEK, 12'd4095, 8'd0, 3'd0, 6'd0));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd63));
        queue_item(make_item(CMD_SEEK, 12'd0, 8'd0, 3'd3, 6'd0));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd0));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd5));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd1));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd7));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd33));
        queue_item(rand_item(CMD_UNUSED));
        queue_item(make_item(CMD_SEEK, 12'd0, 8'd0, 3'd7, 6'd0));
        queue_item(make_item(CMD_READ, 12'd0, 8'd0, 3'd0, 6'd2));
        wait_drained();

        // Random phases; drain fully between them so the sender sits idle
        // with nothing owed at least a few times.
        for (int p = 0; p < PHASES; p++)
        begin
            @(negedge clk);
            while (pending_items.size() < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                    plan_packet();
                else
                    plan_noise();
            end
            wait_drained();
        end

        // Let any late strobe show up before the verdict.
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mfbr_pkg.sv
design/mfbr_byte_mem.sv
design/mfbr_field_align.sv
design/msb_first_bit_reader.sv
sim/tb_msb_first_bit_reader.sv
